// File: rtl/core/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

// File: rtl/core/fprx_pkg.sv
// ----------------------------------------------------------------------------
// fprx_pkg
// Shared types and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package fprx_pkg;
  localparam logic [7:0]  Hdr0     = 8'h55;
  localparam logic [7:0]  Hdr1     = 8'hAA;
  localparam logic [7:0]  CmdShort = 8'h02;
  localparam logic [7:0]  CmdLong  = 8'h08;
  localparam logic [4:0]  ShortLen = 5'd13;
  localparam logic [4:0]  LongLen  = 5'd19;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam int unsigned QDepth   = 2;

  localparam logic [1:0] CfgHand  = 2'd0;
  localparam logic [1:0] CfgUpper = 2'd1;
  localparam logic [1:0] CfgLower = 2'd2;

  typedef enum logic [1:0] {PhHunt, PhSecond, PhData} phase_e;

  typedef enum logic [2:0] {
    StHand = 3'd0, StUpper = 3'd1, StLower = 3'd2, StCrcBad = 3'd3, StIgnored = 3'd4
  } status_e;

  typedef enum logic [1:0] {KShort, KUpper, KLower, KNone} kind_e;

  // classified frame handed from front to back
  typedef struct packed {
    kind_e      kind;
    logic       crc_ok;
    logic [7:0] b9;
    logic [7:0] b10;
    logic [7:0] b13;
    logic [7:0] b15;
    logic [7:0] b16;
  } frame_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction
endpackage

// File: rtl/core/framed_packet_receiver_crc_check_top.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc_check_top
// Framed byte receiver with CRC-16/CCITT check and status reporting.
// ----------------------------------------------------------------------------
// One byte accepted per cycle while full is low; the front steps CRC and frame
// state each byte. On the last frame byte the front writes the queue; the back
// loads its output register from it once that register is free or popped.
// full rises only when the queue holds two frames while the output register is
// occupied. Reset (async, active low) sets phase to hunt and CRC to 0xFFFF,
// clears stored values and queue, restores default addresses 0x0a, 0x06, 0x07.
module framed_packet_receiver_crc_check_top import fprx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output logic [2:0] frame_status_o,
  output logic [7:0] hand_param_first_o,
  output logic [7:0] hand_param_second_o,
  output logic [1:0] percussion_level_o,
  output logic [1:0] unit_knead_o,
  output logic [1:0] unit_walk_o,
  output logic       unit_limit_up_o,
  output logic       unit_limit_down_o,
  output logic [1:0] unit_error_o
);
  logic [7:0] hand_q, upper_q, lower_q;
  logic       frm_valid, q_full, q_empty, q_rd, acc;
  frame_t     frm, q_data;

  assign full = q_full;
  assign acc  = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_q  <= 8'h0a;
      upper_q <= 8'h06;
      lower_q <= 8'h07;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHand:  hand_q  <= cfg_data_i;
        CfgUpper: upper_q <= cfg_data_i;
        CfgLower: lower_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  fprx_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (acc),
    .rx_byte_i,
    .hand_addr_i  (hand_q),
    .upper_addr_i (upper_q),
    .lower_addr_i (lower_q),
    .frm_valid_o  (frm_valid),
    .frm_o        (frm)
  );

  fprx_queue u_queue (
    .clk_i, .rst_ni,
    .wr_i    (frm_valid),
    .wdata_i (frm),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  fprx_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i (q_empty),
    .frm_i     (q_data),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .frame_status_o,
    .hand_param_first_o,
    .hand_param_second_o,
    .percussion_level_o,
    .unit_knead_o,
    .unit_walk_o,
    .unit_limit_up_o,
    .unit_limit_down_o,
    .unit_error_o
  );
endmodule

// File: rtl/core/fprx_front.sv
// ----------------------------------------------------------------------------
// fprx_front
// Header hunt, frame capture, CRC and frame classification.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fprx_front import fprx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] hand_addr_i,
  input  logic [7:0] upper_addr_i,
  input  logic [7:0] lower_addr_i,
  output logic       frm_valid_o,
  output frame_t     frm_o
);
  phase_e      phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  src_q, cmd_q, b9_q, b10_q, b13_q, b15_q, b16_q, crclo_q;
  logic [4:0]  len;
  logic        len_ok, fin;
  logic [15:0] crc_nx;

  assign crc_nx = crc_byte(crc_q, rx_byte_i);

  always_comb begin
    len_ok = 1'b0;
    len    = LongLen;
    if (cmd_q == CmdShort) begin
      len_ok = 1'b1;
      len    = ShortLen;
    end else if (cmd_q == CmdLong) begin
      len_ok = 1'b1;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    fin     = 1'b0;
    if (in_valid_i) begin
      unique case (phase_q)
        PhHunt: if (rx_byte_i == Hdr0) begin
          crc_d   = crc_byte(CrcInit, rx_byte_i);
          phase_d = PhSecond;
        end
        PhSecond: if (rx_byte_i == Hdr1) begin
          crc_d   = crc_nx;
          cnt_d   = 5'd2;
          phase_d = PhData;
        end
        PhData: begin
          cnt_d = cnt_q + 5'd1;
          if (cnt_q >= 5'd8 && !len_ok) begin
            phase_d = PhHunt;
          end else begin
            if (cnt_q < 5'd9 || (cnt_q + 5'd2) < len) crc_d = crc_nx;
            if (cnt_q >= 5'd8 && cnt_q + 5'd1 == len) begin
              fin     = 1'b1;
              phase_d = PhHunt;
            end
          end
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  // outputs
  always_comb begin
    frm_valid_o   = fin;
    frm_o.crc_ok  = (crclo_q == crc_q[7:0]) && (rx_byte_i == crc_q[15:8]);
    frm_o.b9      = b9_q;
    frm_o.b10     = b10_q;
    frm_o.b13     = b13_q;
    frm_o.b15     = b15_q;
    frm_o.b16     = (len == ShortLen) ? 8'h00 : b16_q;
    if (len == ShortLen) begin
      frm_o.kind = (src_q == hand_addr_i) ? KShort : KNone;
    end else if (src_q == upper_addr_i) begin
      frm_o.kind = KUpper;
    end else if (src_q == lower_addr_i) begin
      frm_o.kind = KLower;
    end else begin
      frm_o.kind = KNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cnt_q   <= '0;
      crc_q   <= CrcInit;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
    end
  end

  // payload capture of the byte offsets that matter
  always_ff @(posedge clk_i) begin
    if (in_valid_i && phase_q == PhData) begin
      if (cnt_q == 5'd2)  src_q <= rx_byte_i;
      if (cnt_q == 5'd7)  cmd_q <= rx_byte_i;
      if (cnt_q == 5'd9)  b9_q  <= rx_byte_i;
      if (cnt_q == 5'd10) b10_q <= rx_byte_i;
      if (cnt_q == 5'd13) b13_q <= rx_byte_i;
      if (cnt_q == 5'd15) b15_q <= rx_byte_i;
      if (cnt_q == 5'd16) b16_q <= rx_byte_i;
      if (cnt_q + 5'd2 == len) crclo_q <= rx_byte_i;
    end
  end

  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, cnt_q <= LongLen)
  `ASSERT_CLK(a_fin_hunt, clk_i, rst_ni, fin |=> phase_q == PhHunt)
  `ASSERT_NEVER(a_fin_phase, clk_i, rst_ni, fin && phase_q != PhData)
endmodule

// File: rtl/core/fprx_queue.sv
// ----------------------------------------------------------------------------
// fprx_queue
// Small queue of classified frames between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fprx_queue import fprx_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  frame_t wdata_i,
  output logic   full_o,
  input  logic   rd_i,
  output logic   empty_o,
  output frame_t rdata_o
);
  frame_t     mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] n_q;

  assign full_o  = n_q == 2'(QDepth);
  assign empty_o = n_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      n_q  <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      n_q <= n_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  `ASSERT_NEVER(a_no_ovf, clk_i, rst_ni, wr_i && full_o)
  `ASSERT_NEVER(a_no_udf, clk_i, rst_ni, rd_i && empty_o)
  `ASSERT_CLK(a_cnt, clk_i, rst_ni, n_q <= 2'(QDepth))
endmodule

// File: rtl/core/fprx_back.sv
// ----------------------------------------------------------------------------
// fprx_back
// Applies classified frames to the stored values and builds the status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fprx_back import fprx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  frame_t     frm_i,
  output logic       q_rd_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [2:0] frame_status_o,
  output logic [7:0] hand_param_first_o,
  output logic [7:0] hand_param_second_o,
  output logic [1:0] percussion_level_o,
  output logic [1:0] unit_knead_o,
  output logic [1:0] unit_walk_o,
  output logic       unit_limit_up_o,
  output logic       unit_limit_down_o,
  output logic [1:0] unit_error_o
);
  logic [15:0] hand_q;
  logic [1:0]  perc_q;
  logic        ov_q;
  logic [2:0]  st_q;
  logic [7:0]  unit_q, unit_d;
  status_e     st_d;

  assign q_rd_o  = !q_empty_i && (!ov_q || pop_i);
  assign empty_o = !ov_q;

  always_comb begin
    unit_d = '0;
    st_d   = StIgnored;
    if (!frm_i.crc_ok) begin
      st_d = StCrcBad;
    end else begin
      unique case (frm_i.kind)
        KShort: st_d = StHand;
        KUpper: begin
          st_d   = StUpper;
          unit_d = {frm_i.b16[1:0], frm_i.b15[1], frm_i.b15[0],
                    frm_i.b13[3:2], frm_i.b10[1:0]};
        end
        KLower: begin
          st_d   = StLower;
          unit_d = {frm_i.b16[3:2], frm_i.b15[3], frm_i.b15[2],
                    frm_i.b13[5:4], frm_i.b10[3:2]};
        end
        default: st_d = StIgnored;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_q <= '0;
      perc_q <= '0;
      ov_q   <= 1'b0;
      st_q   <= '0;
      unit_q <= '0;
    end else begin
      if (q_rd_o) begin
        ov_q   <= 1'b1;
        st_q   <= st_d;
        unit_q <= unit_d;
        if (st_d == StHand) hand_q <= {frm_i.b9, frm_i.b10};
        if (st_d == StUpper || st_d == StLower) perc_q <= frm_i.b10[5:4];
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // stored values as of this result: later frames are not yet applied
  assign frame_status_o      = st_q;
  assign hand_param_first_o  = hand_q[15:8];
  assign hand_param_second_o = hand_q[7:0];
  assign percussion_level_o  = perc_q;
  assign unit_knead_o        = unit_q[1:0];
  assign unit_walk_o         = unit_q[3:2];
  assign unit_limit_up_o     = unit_q[4];
  assign unit_limit_down_o   = unit_q[5];
  assign unit_error_o        = unit_q[7:6];

  `ASSERT_CLK(a_st_range, clk_i, rst_ni, ov_q |-> st_q <= 3'd4)
  `ASSERT_CLK(a_unit_zero, clk_i, rst_ni, (ov_q && (st_q == StHand || st_q == StCrcBad || st_q == StIgnored)) |-> unit_q == 8'h00)
  `ASSERT_CLK(a_hold, clk_i, rst_ni, (ov_q && !pop_i) |=> ov_q && $stable(st_q))
endmodule
